/* rtl/adc_inl_inverse_search_top_macros.svh */
// ----------------------------------------------------------------------------
// adc_inl_inverse_search_top_macros
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ADC_INL_INVERSE_SEARCH_TOP_MACROS_SVH
`define ADC_INL_INVERSE_SEARCH_TOP_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define AIIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define AIIS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/aiis_pkg.sv */
// ----------------------------------------------------------------------------
// aiis_pkg
// Shared types and constants of the ADC transfer-curve search block.
// ----------------------------------------------------------------------------
package aiis_pkg;

    // Level words are signed Q24.8
    localparam int LEVEL_W        = 32;
    // Width of the code port
    localparam int CODE_W         = 16;
    // Default number of code bits
    localparam int TABLE_BITS_DEF = 16;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Query beat handed from cell to cell
    typedef struct packed {
        logic                      vld;
        logic signed [LEVEL_W-1:0] level;
    } t_probe;

endpackage

/* rtl/adc_inl_inverse_search_top.sv */
// ----------------------------------------------------------------------------
// adc_inl_inverse_search_top
// ADC transfer curve as a table of transition levels with a search that
// turns a level into the output code.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries i_op and i_level. A load beat
// (i_op = 0) stores the next table entry at the internal write pointer,
// raised to the previous entry if lower, and gives no result. A query beat
// (i_op = 1) gives one o_adc_code beat on the output channel
// (o_valid / i_stall).
// The search runs through a row of TABLE_BITS cells, one per code bit, each
// with its own slice of the table, so one entry read per cell per cycle.
// The result of a query is registered behind the last cell. One item is
// in flight at a time and a query waits until the previous result has left,
// so a new query is not taken before the last one is through; a load is
// taken only when no query is in flight.
// While a result waits on i_stall, loads are still taken but a new query is
// stalled. Reset clears the write pointer, the last stored level and all
// valid flags; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module adc_inl_inverse_search_top
    import aiis_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic signed [LEVEL_W-1:0] i_level,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [CODE_W-1:0]         o_adc_code
);

    localparam int TB = TABLE_BITS;

    logic                      r_busy;
    logic                      r_out_vld;
    logic [CODE_W-1:0]         r_out_code;
    logic [TB-1:0]             r_ptr;
    logic signed [LEVEL_W-1:0] r_last;

    logic                      acc;
    logic                      ld;
    logic                      qry;
    logic signed [LEVEL_W-1:0] stored;
    logic [CODE_W-1:0]         fin_code;

    t_probe        probe_c [TB+1];
    logic [TB-1:0] code_c  [TB+1];

    // input handshake
    assign o_stall = r_busy || ((t_op'(i_op) == OP_QUERY) && r_out_vld);
    assign acc     = i_valid && !o_stall;
    assign ld      = acc && (t_op'(i_op) == OP_LOAD);
    assign qry     = acc && (t_op'(i_op) == OP_QUERY);

    // monotonic clamp; entry zero is stored as given
    assign stored = ((r_ptr != '0) && (i_level < r_last)) ? r_last : i_level;

    // head of the chain: trial code with the top bit set
    assign probe_c[0].vld   = qry;
    assign probe_c[0].level = i_level;
    assign code_c[0]        = TB'(1) << (TB - 1);

    generate
        for (genvar k = 0; k < TB; k++) begin : g_cell
            aiis_cell #(
                .TB(TB),
                .K (k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_wr   (ld),
                .i_ptr  (r_ptr),
                .i_wdata(stored),
                .i_probe(probe_c[k]),
                .i_code (code_c[k]),
                .o_probe(probe_c[k+1]),
                .o_code (code_c[k+1])
            );
        end

        // fit the found code to the port
        if (TB >= CODE_W) begin : g_trunc
            assign fin_code = code_c[TB][CODE_W-1:0];
        end else begin : g_ext
            assign fin_code = {{(CODE_W - TB){1'b0}}, code_c[TB]};
        end
    endgenerate

    // pointer, last level, in-flight flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
            r_ptr     <= '0;
            r_last    <= '0;
        end else begin
            if (ld) begin
                r_ptr  <= r_ptr + TB'(1);
                r_last <= stored;
            end
            if (qry) begin
                r_busy <= 1'b1;
            end else if (probe_c[TB].vld) begin
                r_busy <= 1'b0;
            end
            if (probe_c[TB].vld) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (probe_c[TB].vld) begin
            r_out_code <= fin_code;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_adc_code = r_out_code;

endmodule

/* rtl/aiis_ram.sv */
// ----------------------------------------------------------------------------
// aiis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aiis_ram #(
    parameter int W  = 32,
    parameter int D  = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/aiis_cell.sv */
// ----------------------------------------------------------------------------
// aiis_cell
// One search step: owns the table entries whose lowest set address bit is
// this cell's bit, resolves that bit and sets the next trial bit.
// ----------------------------------------------------------------------------
module aiis_cell
    import aiis_pkg::*;
#(
    parameter int TB = TABLE_BITS_DEF,
    parameter int K  = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // table write, shared by all cells
    input  logic                      i_wr,
    input  logic [TB-1:0]             i_ptr,
    input  logic signed [LEVEL_W-1:0] i_wdata,
    // beat from the previous cell
    input  t_probe                    i_probe,
    input  logic [TB-1:0]             i_code,
    // beat to the next cell
    output t_probe                    o_probe,
    output logic [TB-1:0]             o_code
);

    // bit resolved here and local table geometry
    localparam int B     = TB - 1 - K;
    localparam int DEPTH = 1 << K;
    localparam int AW    = (K > 0) ? K : 1;
    localparam logic [TB-1:0] BIT_M = TB'(1) << B;

    logic                      r_vld;
    logic [TB-1:0]             r_code;
    logic signed [LEVEL_W-1:0] r_level;
    logic signed [LEVEL_W-1:0] rdata;
    logic [AW-1:0]             raddr;
    logic [AW-1:0]             waddr;
    logic                      we;
    logic [TB-1:0]             keep_code;

    // addresses of this cell's slice: the code bits above bit B
    generate
        if (K > 0) begin : g_addr
            assign raddr = i_code[TB-1 -: K];
            assign waddr = i_ptr[TB-1 -: K];
        end else begin : g_addr0
            assign raddr = '0;
            assign waddr = '0;
        end
    endgenerate

    // write lands here when B is the lowest set pointer bit
    assign we = i_wr && i_ptr[B] && ((i_ptr & (BIT_M - TB'(1))) == '0);

    aiis_ram #(
        .W (LEVEL_W),
        .D (DEPTH),
        .AW(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_wdata),
        .i_re   (i_probe.vld),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // beat register, aligned with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_probe.vld;
        end
        r_code  <= i_code;
        r_level <= i_probe.level;
    end

    // drop the trial bit when the entry lies above the level
    assign keep_code = (rdata > r_level) ? (r_code & ~BIT_M) : r_code;

    assign o_code        = keep_code | (BIT_M >> 1);
    assign o_probe.vld   = r_vld;
    assign o_probe.level = r_level;

endmodule

/* rtl/aiis_checker.sv */
// ----------------------------------------------------------------------------
// aiis_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "adc_inl_inverse_search_top_macros.svh"

module aiis_checker
    import aiis_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_op,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CODE_W-1:0] o_adc_code
);

    // a held result keeps its code
    `AIIS_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_adc_code), "result changed while stalled")

    // no query enters while a result waits
    `AIIS_ASSERT(a_qry_block, o_valid && i_valid && i_op |-> o_stall, "query taken with result pending")

    // a query never answers in the next cycle
    `AIIS_ASSERT(a_qry_lat, i_valid && !o_stall && i_op && !o_valid |=> !o_valid, "result too early")

    // reset empties the output
    `AIIS_ASSERT_RST(a_rst_out, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind adc_inl_inverse_search_top aiis_checker u_aiis_checker (.*);
